### rtl/core/pwlm_pkg.sv
// ----------------------------------------------------------------------------
// pwlm_pkg
// Shared types, constants and helpers for the pressure-weighted layer mean.
// ----------------------------------------------------------------------------
package pwlm_pkg;

  localparam int PresW  = 17;
  localparam int ValW   = 24;
  localparam int IdxW   = 6;
  localparam int MaxLayersOut = 63;
  localparam int DefMaxPoints = 256;
  localparam int DefMaxLevels = 64;

  // Trapezoid sum width: |v+v| < 2^25, dp < 2^18 signed, up to ~4k terms
  localparam int SumW   = 58;
  localparam int ThickW = 19;  // 2*thickness, signed

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_POINT   = 2'd1;
  localparam logic [1:0] CMD_LEVEL   = 2'd2;
  localparam logic [1:0] CMD_COMPUTE = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic layer_start;  // load bounds of current layer, clear sum
    logic point_acc;    // apply point read data if inside layer
    logic top_acc;      // add closing trapezoid of layer
    logic div_start;    // start divider
  } pwlm_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic div_done;
  } pwlm_sts_t;

endpackage

### rtl/core/pwlm_ram.sv
// ----------------------------------------------------------------------------
// pwlm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwlm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/pwlm_div.sv
// ----------------------------------------------------------------------------
// pwlm_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero, with 24-bit saturation of the quotient.
// ----------------------------------------------------------------------------
module pwlm_div
  import pwlm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SumW-1:0]  dividend,
  input  logic signed [ThickW-1:0] divisor,
  output logic                    done,
  output logic signed [ValW-1:0]  quotient
);

  localparam int CntW = $clog2(SumW + 1);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [SumW-1:0] q;     // shifts out dividend bits, in quotient bits
  logic [ThickW:0] rem;
  logic [ThickW-1:0] dmag;
  logic            neg;
  logic [ThickW:0] trial;
  logic [ThickW:0] rem_sh;
  logic [SumW-1:0] qs;

  assign rem_sh = {rem[ThickW-1:0], q[SumW-1]};
  assign trial  = rem_sh - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(SumW);
        q    <= dividend[SumW-1] ? SumW'(-dividend) : dividend;
        dmag <= divisor[ThickW-1] ? ThickW'(-divisor) : divisor;
        neg  <= dividend[SumW-1] ^ divisor[ThickW-1];
        rem  <= '0;
      end else if (busy) begin
        if (!trial[ThickW]) begin
          rem <= trial;
          q   <= {q[SumW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q   <= {q[SumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign fix and saturation (magnitude fits SumW unsigned bits)
  assign qs = neg ? SumW'(-q) : q;
  always_comb begin
    if (!neg && q > SumW'(24'h7FFFFF)) quotient = 24'sh7FFFFF;
    else if (neg && q > SumW'(24'h800000)) quotient = -24'sh800000;
    else quotient = qs[ValW-1:0];
  end

endmodule

### rtl/core/pwlm_datapath.sv
// ----------------------------------------------------------------------------
// pwlm_datapath
// Layer bounds, trapezoid accumulator and mean divider.
// ----------------------------------------------------------------------------
module pwlm_datapath
  import pwlm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  pwlm_cmd_t              cmd,
  input  logic [PresW-1:0]       lo_p,    // level k read data
  input  logic signed [ValW-1:0] lo_v,
  input  logic [PresW-1:0]       hi_p,    // level k+1 read data
  input  logic signed [ValW-1:0] hi_v,
  input  logic [PresW-1:0]       pt_p,
  input  logic signed [ValW-1:0] pt_v,
  output pwlm_sts_t              sts,
  output logic                   zero_thick,
  output logic signed [ValW-1:0] mean
);

  logic [PresW-1:0]       bot_p, top_p, prev_p;
  logic signed [ValW-1:0] top_v, prev_v;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] sum_next;
  logic signed [ThickW-1:0] thick2;
  logic in_layer;
  logic signed [ValW:0]   vsum;
  logic signed [PresW:0]  dp;
  logic [PresW-1:0]       end_p;
  logic signed [ValW-1:0] end_v;
  logic signed [ValW+PresW+1:0] prod;
  logic signed [ValW+PresW+1:0] prod_r;
  logic                   prod_vld;
  logic signed [ValW-1:0] qout;

  assign in_layer = (pt_p > top_p) && (pt_p < bot_p);
  assign end_p  = cmd.top_acc ? top_p : pt_p;
  assign end_v  = cmd.top_acc ? top_v : pt_v;
  assign vsum   = (ValW+1)'(end_v) + (ValW+1)'(prev_v);
  assign dp     = $signed({1'b0, prev_p}) - $signed({1'b0, end_p});
  assign prod   = vsum * dp;

  // running sum including the product still in the pipeline register
  assign sum_next = prod_vld ? sum + SumW'(prod_r) : sum;

  // one term per cycle: product registered, summed next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (cmd.point_acc && in_layer) || cmd.top_acc;
    end
    prod_r <= prod;
    if (cmd.layer_start) begin
      bot_p  <= lo_p;
      prev_p <= lo_p;
      prev_v <= lo_v;
      top_p  <= hi_p;
      top_v  <= hi_v;
      thick2 <= ThickW'($signed({1'b0, lo_p}) - $signed({1'b0, hi_p})) <<< 1;
      sum    <= '0;
    end else begin
      if ((cmd.point_acc && in_layer) || cmd.top_acc) begin
        prev_p <= end_p;
        prev_v <= end_v;
      end
      if (prod_vld) sum <= sum_next;
    end
  end

  pwlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_next),
    .divisor  (thick2),
    .done     (sts.div_done),
    .quotient (qout)
  );

  assign zero_thick = (thick2 == '0);
  assign mean       = zero_thick ? '0 : qout;

endmodule

### rtl/core/pwlm_ctrl.sv
// ----------------------------------------------------------------------------
// pwlm_ctrl
// Sequencer: loads, clears and the layer walk of a compute request.
// ----------------------------------------------------------------------------
module pwlm_ctrl
  import pwlm_pkg::*;
#(
  parameter int MaxPoints = DefMaxPoints,
  parameter int MaxLevels = DefMaxLevels,
  localparam int PaW = $clog2(MaxPoints),
  localparam int LaW = $clog2(MaxLevels),
  localparam int PcW = $clog2(MaxPoints + 1),
  localparam int LcW = $clog2(MaxLevels + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  logic [PresW-1:0] min_p,
  input  logic [PresW-1:0] hi_p,     // level k+1 pressure, later level k+2
  output logic             pt_we,
  output logic [PaW-1:0]   pt_waddr,
  output logic [PaW-1:0]   pt_raddr,
  output logic             lv_we,
  output logic [LaW-1:0]   lv_waddr,
  output logic [LaW-1:0]   lv_raddr_lo,
  output logic [LaW-1:0]   lv_raddr_hi,
  output pwlm_cmd_t        cmd,
  input  pwlm_sts_t        sts,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [IdxW-1:0]  res_idx,
  output logic             res_none,
  output logic             res_last,
  output logic             ovf
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LREAD = 3'd1;  // level read in flight
  localparam logic [2:0] S_CHECK = 3'd2;  // test upper level, start layer
  localparam logic [2:0] S_PTS   = 3'd3;  // stream points
  localparam logic [2:0] S_TOP   = 3'd4;  // closing trapezoid
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_ACC   = 3'd7;  // last term lands, divide starts

  logic [2:0]     state;
  logic [PcW-1:0] pcnt;
  logic [LcW-1:0] lcnt;
  logic [LaW-1:0] k;
  logic [PcW-1:0] pi;        // point address issued
  logic           pv;        // point read data valid
  logic [IdxW:0]  n;
  logic           accept;
  logic           more;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign pt_we    = accept && in_cmd == CMD_POINT && pcnt < PcW'(MaxPoints);
  assign lv_we    = accept && in_cmd == CMD_LEVEL && lcnt < LcW'(MaxLevels);
  assign pt_waddr = pcnt[PaW-1:0];
  assign lv_waddr = lcnt[LaW-1:0];
  assign pt_raddr = pi[PaW-1:0];
  assign lv_raddr_lo = k;
  // upper bound for the layer start, then the next layer's upper level
  assign lv_raddr_hi = (state == S_LREAD) ? LaW'(k + 1'b1) : LaW'(k + 2'd2);

  // another layer after k exists and qualifies, and the result count limit is not reached
  assign more = (LcW'(k) + LcW'(2) < lcnt) && (hi_p >= min_p) &&
                (n + 1'b1 < (IdxW+1)'(MaxLayersOut));

  always_comb begin
    cmd = '0;
    cmd.layer_start = (state == S_CHECK) && (hi_p >= min_p);
    cmd.point_acc   = (state == S_PTS) && pv;
    cmd.top_acc     = (state == S_TOP);
    cmd.div_start   = (state == S_ACC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pcnt      <= '0;
      lcnt      <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
      k         <= '0;
      n         <= '0;
      pv        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_CLEAR: begin
                pcnt <= '0;
                lcnt <= '0;
                ovf  <= 1'b0;
              end
              CMD_POINT: begin
                if (pt_we) pcnt <= pcnt + 1'b1;
                else ovf <= 1'b1;
              end
              CMD_LEVEL: begin
                if (lv_we) lcnt <= lcnt + 1'b1;
                else ovf <= 1'b1;
              end
              default: begin
                k <= '0;
                n <= '0;
                if (lcnt < LcW'(2)) begin
                  res_valid <= 1'b1;
                  res_idx   <= '0;
                  res_none  <= 1'b1;
                  res_last  <= 1'b1;
                  state     <= S_OUT;
                end else begin
                  state <= S_LREAD;
                end
              end
            endcase
          end
        end
        S_LREAD: state <= S_CHECK;
        S_CHECK: begin
          if (hi_p >= min_p) begin
            pi    <= '0;
            pv    <= 1'b0;
            state <= S_PTS;
          end else begin
            res_valid <= 1'b1;
            res_idx   <= '0;
            res_none  <= (n == '0);
            res_last  <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_PTS: begin
          // issue one address per cycle; its data lands in the next cycle
          pv <= (pi < pcnt);
          if (pi < pcnt) pi <= pi + 1'b1;
          else if (!pv) state <= S_TOP;
        end
        S_TOP: state <= S_ACC;
        S_ACC: state <= S_DIV;
        S_DIV: begin
          if (sts.div_done) begin
            res_valid <= 1'b1;
            res_idx   <= IdxW'(k);
            res_none  <= 1'b0;
            res_last  <= !more;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              n     <= n + 1'b1;
              k     <= k + 1'b1;
              state <= S_LREAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/pressure_weighted_layer_mean_core.sv
// ----------------------------------------------------------------------------
// pressure_weighted_layer_mean_core
// Stores sounding points and boundary levels; on compute emits the
// trapezoidal pressure-weighted mean of each qualifying layer.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata {value,pressure,command}
// m_axis    out  m_axis_tvalid/tready      tdata, tuser flags, tlast
// cfg       in   cfg_valid/cfg_ready       min_pressure
//
// Clear and load requests are handled in the idle state.
// A compute request walks the layers: per layer one point read per cycle
// from the point RAM, then a serial divide. A compute with fewer than two
// stored levels answers with a no-layer result straight from idle.
// The next request is taken only once the last result has been delivered.
// A stalled m_axis holds the result and the walk. rst is synchronous.
// ----------------------------------------------------------------------------
module pressure_weighted_layer_mean_core
  import pwlm_pkg::*;
#(
  parameter int MaxPoints = DefMaxPoints,
  parameter int MaxLevels = DefMaxLevels
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // command[1:0], pressure[18:2], sample_value[42:19]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // layer_index[5:0], layer_mean[29:6]
  output logic [2:0]  m_axis_tuser,   // zero_thickness, load_overflow, no_layers
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  localparam int PaW = $clog2(MaxPoints);
  localparam int LaW = $clog2(MaxLevels);

  logic [PresW-1:0] min_p;
  logic [1:0]       in_cmd;
  logic [PresW-1:0] in_p;
  logic [ValW-1:0]  in_v;
  logic             pt_we, lv_we;
  logic [PaW-1:0]   pt_waddr, pt_raddr;
  logic [LaW-1:0]   lv_waddr, lv_ra_lo, lv_ra_hi;
  logic [PresW+ValW-1:0] pt_rd, lo_rd, hi_rd;
  pwlm_cmd_t        cmd;
  pwlm_sts_t        sts;
  logic [IdxW-1:0]  res_idx;
  logic             res_none, res_last, ovf, zero_thick;
  logic signed [ValW-1:0] mean;

  assign in_cmd = s_axis_tdata[1:0];
  assign in_p   = s_axis_tdata[18:2];
  assign in_v   = s_axis_tdata[42:19];

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) min_p <= '0;
    else if (cfg_valid) min_p <= cfg_data;
  end

  pwlm_ram #(.Width(PresW + ValW), .Depth(MaxPoints)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata({in_v, in_p}),
    .raddr(pt_raddr), .rdata(pt_rd)
  );
  pwlm_ram #(.Width(PresW + ValW), .Depth(MaxLevels)) u_lo_ram (
    .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata({in_v, in_p}),
    .raddr(lv_ra_lo), .rdata(lo_rd)
  );
  pwlm_ram #(.Width(PresW + ValW), .Depth(MaxLevels)) u_hi_ram (
    .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata({in_v, in_p}),
    .raddr(lv_ra_hi), .rdata(hi_rd)
  );

  pwlm_ctrl #(.MaxPoints(MaxPoints), .MaxLevels(MaxLevels)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
    .min_p(min_p), .hi_p(hi_rd[PresW-1:0]),
    .pt_we(pt_we), .pt_waddr(pt_waddr), .pt_raddr(pt_raddr),
    .lv_we(lv_we), .lv_waddr(lv_waddr), .lv_raddr_lo(lv_ra_lo), .lv_raddr_hi(lv_ra_hi),
    .cmd(cmd), .sts(sts),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_idx(res_idx), .res_none(res_none), .res_last(res_last), .ovf(ovf)
  );

  pwlm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .lo_p(lo_rd[PresW-1:0]), .lo_v(lo_rd[PresW+ValW-1:PresW]),
    .hi_p(hi_rd[PresW-1:0]), .hi_v(hi_rd[PresW+ValW-1:PresW]),
    .pt_p(pt_rd[PresW-1:0]), .pt_v(pt_rd[PresW+ValW-1:PresW]),
    .sts(sts), .zero_thick(zero_thick), .mean(mean)
  );

  assign m_axis_tdata = {2'b00, (res_none ? 24'd0 : mean), res_idx};
  assign m_axis_tuser = {res_none, ovf, (!res_none && zero_thick)};
  assign m_axis_tlast = res_last;

  // no request taken while a result is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
  // a no-layer result is always the last one
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tlast) else $error("no_layers not last");
  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule
